// ----- src/fsa_pkg.sv -----
package fsa_pkg;

  localparam int unsigned FSA_DATA_DEPTH   = 32;
  localparam int unsigned FSA_RETURN_DEPTH = 32;
  localparam int unsigned FSA_WORD_WIDTH   = 32;

  typedef enum logic [5:0] {
    OP_LIT            = 6'd0,
    OP_DUP            = 6'd1,
    OP_OVER           = 6'd2,
    OP_TWO_DUP        = 6'd3,
    OP_TWO_OVER       = 6'd4,
    OP_FOUR_DUP       = 6'd5,
    OP_SWAP           = 6'd6,
    OP_ROT            = 6'd7,
    OP_NROT           = 6'd8,
    OP_TWO_SWAP       = 6'd9,
    OP_PICK           = 6'd10,
    OP_DROP           = 6'd11,
    OP_NIP            = 6'd12,
    OP_TWO_DROP       = 6'd13,
    OP_TO_R           = 6'd14,
    OP_R_FROM         = 6'd15,
    OP_R_FETCH        = 6'd16,
    OP_ADD            = 6'd17,
    OP_SUB            = 6'd18,
    OP_MUL            = 6'd19,
    OP_DIV            = 6'd20,
    OP_MOD            = 6'd21,
    OP_STAR_SLASH     = 6'd22,
    OP_STAR_SLASH_MOD = 6'd23,
    OP_AND            = 6'd24,
    OP_OR             = 6'd25,
    OP_XOR            = 6'd26,
    OP_NEGATE         = 6'd27,
    OP_ABS            = 6'd28,
    OP_ZERO_EQ        = 6'd29,
    OP_ZERO_LT        = 6'd30,
    OP_ZERO_GT        = 6'd31,
    OP_EQ             = 6'd32,
    OP_GT             = 6'd33,
    OP_LT             = 6'd34,
    OP_NE             = 6'd35,
    OP_GE             = 6'd36,
    OP_LE             = 6'd37
  } fsa_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } fsa_status_e;

  typedef struct packed {
    logic [5:0]         op;
    logic signed [31:0] value;
  } fsa_in_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [5:0]         data_depth;
    logic [5:0]         return_depth;
    logic [1:0]         status;
  } fsa_out_t;

  // start strobes toward the multiply/divide unit
  typedef struct packed {
    logic mul_go;
    logic div_go;
  } fsa_md_req_t;

  // items the word needs on the data stack
  function automatic logic [2:0] need_of(input fsa_op_e op);
    logic [2:0] n;
    case (op)
      OP_LIT, OP_R_FROM, OP_R_FETCH:                      n = 3'd0;
      OP_DUP, OP_DROP, OP_TO_R, OP_NEGATE, OP_ABS,
      OP_ZERO_EQ, OP_ZERO_LT, OP_ZERO_GT:                 n = 3'd1;
      OP_ROT, OP_NROT, OP_STAR_SLASH, OP_STAR_SLASH_MOD:  n = 3'd3;
      OP_TWO_OVER, OP_FOUR_DUP, OP_TWO_SWAP:              n = 3'd4;
      OP_OVER, OP_TWO_DUP, OP_SWAP, OP_PICK, OP_NIP, OP_TWO_DROP,
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
      OP_EQ, OP_GT, OP_LT, OP_NE, OP_GE, OP_LE:           n = 3'd2;
      default:                                            n = 3'd0;
    endcase
    return n;
  endfunction

  // net change of the data depth
  function automatic logic signed [3:0] grow_of(input fsa_op_e op);
    logic signed [3:0] g;
    case (op)
      OP_LIT, OP_DUP, OP_OVER, OP_R_FROM, OP_R_FETCH:     g = 4'sd1;
      OP_TWO_DUP, OP_TWO_OVER:                            g = 4'sd2;
      OP_FOUR_DUP:                                        g = 4'sd4;
      OP_TWO_DROP, OP_STAR_SLASH:                         g = -4'sd2;
      OP_DROP, OP_NIP, OP_TO_R, OP_STAR_SLASH_MOD,
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
      OP_EQ, OP_GT, OP_LT, OP_NE, OP_GE, OP_LE:           g = -4'sd1;
      default:                                            g = 4'sd0;
    endcase
    return g;
  endfunction

endpackage

// ----- src/fsa_ram.sv -----
module fsa_ram import fsa_pkg::*; #(
  parameter int unsigned DEPTH = FSA_DATA_DEPTH,
  parameter int unsigned WIDTH = FSA_WORD_WIDTH,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/fsa_muldiv.sv -----
module fsa_muldiv import fsa_pkg::*; #(
  parameter int unsigned W = FSA_WORD_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fsa_md_req_t req_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic        done_o,
  output logic [W-1:0] prod_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int unsigned CNW = $clog2(W + 1);

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_e;

  md_state_e      state_q;
  logic [CNW-1:0] cnt_q;
  logic           done_q;
  logic [W-1:0]   acc_q, mc_q, ml_q;
  logic [W-1:0]   quo_q, rem_q, dv_q;
  logic           na_q, nq_q;
  logic [W:0]     sh, diff;
  logic [W-1:0]   rem_d, quo_d;

  // one restoring step per cycle
  always_comb begin
    sh    = {rem_q, quo_q[W-1]};
    diff  = sh - {1'b0, dv_q};
    rem_d = diff[W] ? sh[W-1:0] : diff[W-1:0];
    quo_d = {quo_q[W-2:0], ~diff[W]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MD_IDLE: begin
          if (req_i.mul_go) begin
            state_q <= MD_MUL;
            cnt_q   <= CNW'(W);
          end else if (req_i.div_go) begin
            state_q <= MD_DIV;
            cnt_q   <= CNW'(W);
          end
        end
        MD_MUL, MD_DIV: begin
          cnt_q <= cnt_q - CNW'(1);
          if (cnt_q == CNW'(1)) begin
            state_q <= MD_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= MD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == MD_IDLE && req_i.mul_go) begin
      acc_q <= '0;
      mc_q  <= a_i;
      ml_q  <= b_i;
    end else if (state_q == MD_IDLE && req_i.div_go) begin
      quo_q <= a_i[W-1] ? -a_i : a_i;
      dv_q  <= b_i[W-1] ? -b_i : b_i;
      rem_q <= '0;
      na_q  <= a_i[W-1];
      nq_q  <= a_i[W-1] ^ b_i[W-1];
    end else if (state_q == MD_MUL) begin
      if (ml_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q << 1;
      ml_q <= ml_q >> 1;
    end else if (state_q == MD_DIV) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
  assign quot_o = nq_q ? -quo_q : quo_q;
  assign rem_o  = na_q ? -rem_q : rem_q;

endmodule

// ----- src/forth_stack_alu_unit_core.sv -----
// forth stack and alu unit: runs one stack or alu word per command on a top-of-stack
// register backed by a data stack memory and a return stack memory. a command word
// is taken when start is high and busy is low. busy drops in the cycle the result word
// is shown, so the next command can be taken at the edge that ends that cycle. the
// result is on result_o for exactly one cycle with done_o high and cannot be held off
// by the receiver, so it must be taken in that cycle. a word fetches 0 to 3 data stack
// items and writes back 0 to 7; a word refused by a check goes straight to the finish
// state. reads go one at a time, an address state then a data state, and writes go
// one per cycle. multiply and divide go through a bit-serial unit, and star-slash
// makes two passes. on underflow, overflow or a zero divisor nothing changes and the
// status says why. both memories start undefined and no entry beyond the current
// depth is ever used, so no clearing pass runs after reset.
module forth_stack_alu_unit_core import fsa_pkg::*; #(
  parameter int unsigned DATA_DEPTH   = FSA_DATA_DEPTH,
  parameter int unsigned RETURN_DEPTH = FSA_RETURN_DEPTH,
  parameter int unsigned WORD_WIDTH   = FSA_WORD_WIDTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  fsa_in_t  cmd_i,
  output logic     busy,
  output logic     done_o,
  output fsa_out_t result_o
);

  localparam int unsigned W   = WORD_WIDTH;
  localparam int unsigned DCW = $clog2(DATA_DEPTH + 2);
  localparam int unsigned RCW = $clog2(RETURN_DEPTH + 1);
  localparam int unsigned DAW = $clog2(DATA_DEPTH);
  localparam int unsigned RAW = $clog2(RETURN_DEPTH);
  localparam int unsigned CW  = (W > DCW) ? W : DCW;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_RD_ADDR  = 10'b0000000010,
    S_RD_DATA  = 10'b0000000100,
    S_MUL_GO   = 10'b0000001000,
    S_MUL_WAIT = 10'b0000010000,
    S_DIV_GO   = 10'b0000100000,
    S_DIV_WAIT = 10'b0001000000,
    S_EXEC     = 10'b0010000000,
    S_WR       = 10'b0100000000,
    S_FIN      = 10'b1000000000
  } state_e;

  // where to go once the operand window is loaded
  function automatic state_e after_load(input fsa_op_e op);
    state_e s;
    case (op)
      OP_MUL, OP_STAR_SLASH, OP_STAR_SLASH_MOD: s = S_MUL_GO;
      OP_DIV, OP_MOD:                           s = S_DIV_GO;
      default:                                  s = S_EXEC;
    endcase
    return s;
  endfunction

  state_e      state_q, state_d;
  logic [W-1:0]   top_q;
  logic [DCW-1:0] dc_q;
  logic [RCW-1:0] rc_q;
  logic [1:0]     i_q;
  logic [2:0]     j_q;
  logic           done_q;

  fsa_op_e        op_q;
  logic [W-1:0]   lit_q;
  logic           skip_q;
  fsa_status_e    status_q;
  logic [2:0]     l_q;
  logic [3:0]     m_q;
  logic [DCW-1:0] dn_q;
  logic [W-1:0]   w_q [1:3];   // items one to three under the top
  logic [W-1:0]   nw_q [8];    // new window, index 0 is the new top
  fsa_out_t       result_q;

  // accept-time decode
  fsa_op_e           acc_op;
  logic [2:0]        need, k;
  logic signed [3:0] grow;
  logic signed [4:0] msum;
  logic [3:0]        m_acc;
  logic [2:0]        l_acc;
  logic [DCW-1:0]    dn_acc;
  fsa_status_e       st_acc;
  logic              skip_acc;

  // memories and arithmetic
  logic [W-1:0]   d_rdata, r_rdata;
  logic [DAW-1:0] d_raddr, d_waddr;
  logic           d_we, r_we;
  fsa_md_req_t    md_req;
  logic           md_done;
  logic [W-1:0]   md_a, md_b, md_prod, md_quot, md_rem;

  logic [W-1:0]   nw_d [8];
  logic [W-1:0]   t0, t1, t2, t3;
  logic [1:0]     last_idx;
  logic [W-1:0]   ntop, fin_top;
  logic [DCW-1:0] fin_d;
  logic [RCW-1:0] rc_next, fin_rc;

  assign acc_op = fsa_op_e'(cmd_i.op);
  assign need   = need_of(acc_op);
  assign grow   = grow_of(acc_op);
  assign k      = (need == 3'd0) ? 3'd1 : need;
  assign msum   = $signed({2'b00, k}) + grow;
  // pick loads one item at a computed depth and leaves a one-item window
  assign m_acc  = (acc_op == OP_PICK) ? 4'd1 : msum[3:0];
  assign l_acc  = (acc_op == OP_PICK) ? 3'd2 :
                  (m_acc == 4'd0)     ? k + 3'd1 : k;
  assign dn_acc = DCW'($signed({1'b0, dc_q}) + grow);

  // checks in priority order: underflow, overflow, divide by zero
  always_comb begin
    st_acc   = ST_OK;
    skip_acc = 1'b0;
    if (cmd_i.op > OP_LE) begin
      skip_acc = 1'b1;   // unused code, no operation
    end else if (dc_q < DCW'(need)) begin
      st_acc = ST_UNDER;
    end else if ((acc_op == OP_R_FROM || acc_op == OP_R_FETCH) && rc_q == '0) begin
      st_acc = ST_UNDER;
    end else if (acc_op == OP_PICK && CW'(top_q) > CW'(dc_q - DCW'(2))) begin
      st_acc = ST_UNDER;
    end else if (grow > 4'sd0 &&
                 ({1'b0, dc_q} + (DCW+1)'(grow[2:0])) > (DCW+1)'(DATA_DEPTH + 1)) begin
      st_acc = ST_OVER;
    end else if (acc_op == OP_TO_R && rc_q >= RCW'(RETURN_DEPTH)) begin
      st_acc = ST_OVER;
    end else if ((acc_op inside {OP_DIV, OP_MOD, OP_STAR_SLASH, OP_STAR_SLASH_MOD}) &&
                 top_q == '0) begin
      st_acc = ST_DIVZ;
    end
    if (st_acc != ST_OK) begin
      skip_acc = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if (skip_acc)            state_d = S_FIN;
          else if (l_acc == 3'd1)  state_d = after_load(acc_op);
          else                     state_d = S_RD_ADDR;
        end
      end
      S_RD_ADDR: state_d = S_RD_DATA;
      S_RD_DATA: begin
        if (3'(i_q) == l_q - 3'd1) state_d = after_load(op_q);
        else                       state_d = S_RD_ADDR;
      end
      S_MUL_GO:   state_d = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (md_done) state_d = (op_q == OP_MUL) ? S_EXEC : S_DIV_GO;
      end
      S_DIV_GO:   state_d = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (md_done) state_d = S_EXEC;
      end
      S_EXEC: state_d = (m_q >= 4'd2) ? S_WR : S_FIN;
      S_WR: begin
        if (4'(j_q) == m_q - 4'd1) state_d = S_FIN;
      end
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // data stack: item i sits at depth-1-i, top is the register
  assign d_raddr = (op_q == OP_PICK) ? DAW'(dc_q) - DAW'(2) - DAW'(top_q)
                                     : DAW'(dc_q - DCW'(1) - DCW'(i_q));
  assign d_waddr = DAW'(dn_q - DCW'(1) - DCW'(j_q));
  assign d_we    = (state_q == S_WR) && (DCW'(j_q) < dn_q);

  fsa_ram #(
    .DEPTH (DATA_DEPTH),
    .WIDTH (W)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (nw_q[j_q]),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  // return stack top is read every cycle, so it is ready in the cycle after accept
  assign r_we = (state_q == S_FIN) && !skip_q && (op_q == OP_TO_R);

  fsa_ram #(
    .DEPTH (RETURN_DEPTH),
    .WIDTH (W)
  ) u_return_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (RAW'(rc_q)),
    .wdata_i (top_q),
    .raddr_i (RAW'(rc_q - RCW'(1))),
    .rdata_o (r_rdata)
  );

  assign t0 = top_q;
  assign t1 = w_q[1];
  assign t2 = w_q[2];
  assign t3 = w_q[3];

  // multiply runs second*top, or third*second ahead of a star-slash divide
  assign md_req.mul_go = (state_q == S_MUL_GO);
  assign md_req.div_go = (state_q == S_DIV_GO);
  assign md_a = (state_q == S_MUL_GO) ? ((op_q == OP_MUL) ? t1 : t2)
                                      : ((op_q == OP_DIV || op_q == OP_MOD) ? t1 : md_prod);
  assign md_b = (state_q == S_MUL_GO && op_q != OP_MUL) ? t1 : t0;

  fsa_muldiv #(
    .W (W)
  ) u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (md_a),
    .b_i    (md_b),
    .done_o (md_done),
    .prod_o (md_prod),
    .quot_o (md_quot),
    .rem_o  (md_rem)
  );

  // new window from the loaded one, binary words take second op top
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      nw_d[n] = '0;
    end
    case (op_q)
      OP_LIT:      begin nw_d[0] = lit_q; nw_d[1] = t0; end
      OP_DUP:      begin nw_d[0] = t0; nw_d[1] = t0; end
      OP_OVER:     begin nw_d[0] = t1; nw_d[1] = t0; nw_d[2] = t1; end
      OP_TWO_DUP:  begin nw_d[0] = t0; nw_d[1] = t1; nw_d[2] = t0; nw_d[3] = t1; end
      OP_TWO_OVER: begin
        nw_d[0] = t2; nw_d[1] = t3; nw_d[2] = t0;
        nw_d[3] = t1; nw_d[4] = t2; nw_d[5] = t3;
      end
      OP_FOUR_DUP: begin
        nw_d[0] = t0; nw_d[1] = t1; nw_d[2] = t2; nw_d[3] = t3;
        nw_d[4] = t0; nw_d[5] = t1; nw_d[6] = t2; nw_d[7] = t3;
      end
      OP_SWAP:     begin nw_d[0] = t1; nw_d[1] = t0; end
      OP_ROT:      begin nw_d[0] = t2; nw_d[1] = t0; nw_d[2] = t1; end
      OP_NROT:     begin nw_d[0] = t1; nw_d[1] = t2; nw_d[2] = t0; end
      OP_TWO_SWAP: begin nw_d[0] = t2; nw_d[1] = t3; nw_d[2] = t0; nw_d[3] = t1; end
      OP_PICK:     nw_d[0] = t1;
      OP_NIP:      nw_d[0] = t0;
      OP_R_FROM, OP_R_FETCH: begin nw_d[0] = r_rdata; nw_d[1] = t0; end
      OP_ADD:      nw_d[0] = t1 + t0;
      OP_SUB:      nw_d[0] = t1 - t0;
      OP_MUL:      nw_d[0] = md_prod;
      OP_DIV:      nw_d[0] = md_quot;
      OP_MOD:      nw_d[0] = md_rem;
      OP_STAR_SLASH:     nw_d[0] = md_quot;
      OP_STAR_SLASH_MOD: begin nw_d[0] = md_quot; nw_d[1] = md_rem; end
      OP_AND:      nw_d[0] = t1 & t0;
      OP_OR:       nw_d[0] = t1 | t0;
      OP_XOR:      nw_d[0] = t1 ^ t0;
      OP_NEGATE:   nw_d[0] = -t0;
      OP_ABS:      nw_d[0] = t0[W-1] ? -t0 : t0;
      OP_ZERO_EQ:  nw_d[0] = {W{t0 == '0}};
      OP_ZERO_LT:  nw_d[0] = {W{t0[W-1]}};
      OP_ZERO_GT:  nw_d[0] = {W{$signed(t0) > $signed(W'(0))}};
      OP_EQ:       nw_d[0] = {W{t1 == t0}};
      OP_GT:       nw_d[0] = {W{$signed(t1) > $signed(t0)}};
      OP_LT:       nw_d[0] = {W{$signed(t1) < $signed(t0)}};
      OP_NE:       nw_d[0] = {W{t1 != t0}};
      OP_GE:       nw_d[0] = {W{$signed(t1) >= $signed(t0)}};
      OP_LE:       nw_d[0] = {W{$signed(t1) <= $signed(t0)}};
      default:     nw_d[0] = '0;   // drop, 2drop, >r leave an empty window
    endcase
  end

  // an empty window pulls the next item up into the top register
  assign last_idx = (l_q == 3'd1) ? 2'd1 : 2'(l_q - 3'd1);
  assign ntop     = (m_q == 4'd0) ? w_q[last_idx] : nw_q[0];

  always_comb begin
    rc_next = rc_q;
    if (op_q == OP_TO_R)        rc_next = rc_q + RCW'(1);
    else if (op_q == OP_R_FROM) rc_next = rc_q - RCW'(1);
  end

  assign fin_top = skip_q ? top_q : ntop;
  assign fin_d   = skip_q ? dc_q  : dn_q;
  assign fin_rc  = skip_q ? rc_q  : rc_next;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      top_q   <= '0;
      dc_q    <= '0;
      rc_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FIN);
      case (state_q)
        S_IDLE:    i_q <= 2'd1;
        S_RD_DATA: i_q <= i_q + 2'd1;
        S_EXEC:    j_q <= 3'd1;
        S_WR:      j_q <= j_q + 3'd1;
        S_FIN: begin
          if (!skip_q) begin
            top_q <= ntop;
            dc_q  <= dn_q;
            rc_q  <= rc_next;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start) begin
          op_q     <= acc_op;
          lit_q    <= W'(cmd_i.value);
          skip_q   <= skip_acc;
          status_q <= st_acc;
          l_q      <= l_acc;
          m_q      <= m_acc;
          dn_q     <= dn_acc;
        end
      end
      S_RD_DATA: begin
        // items past the depth read as zero
        w_q[i_q] <= (op_q == OP_PICK || DCW'(i_q) < dc_q) ? d_rdata : '0;
      end
      S_EXEC: nw_q <= nw_d;
      S_FIN: begin
        result_q.top_value    <= (fin_d == '0) ? '0 : 32'(fin_top);
        result_q.data_depth   <= 6'(fin_d);
        result_q.return_depth <= 6'(fin_rc);
        result_q.status       <= status_q;
      end
      default: ;
    endcase
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ----- tb/tb_forth_stack_alu_unit_core.sv -----
`timescale 1ns / 100ps

module tb_forth_stack_alu_unit_core;
  import fsa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 120;  // beyond a two-pass star-slash
  localparam logic [31:0] MIN_WORD = 32'h8000_0000;
  localparam logic [31:0] MAX_WORD = 32'h7fff_ffff;
  localparam logic [31:0] TRUE_WORD = 32'hffff_ffff;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  fsa_in_t  cmd_i;
  logic     busy;
  logic     done_o;
  fsa_out_t result_o;

  forth_stack_alu_unit_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .cmd_i   (cmd_i),
    .busy    (busy),
    .done_o  (done_o),
    .result_o(result_o)
  );

  // mirror of the machine: top register, data stack below it, return stack
  logic [31:0] tos_word;
  logic [31:0] data_mem [FSA_DATA_DEPTH];
  int          data_cnt;
  logic [31:0] ret_mem [FSA_RETURN_DEPTH];
  int          ret_cnt;

  // items each word consumes and the net data depth change, by opcode
  int need_cnt [38] = '{0, 1, 2, 2, 4, 4, 2, 3, 3, 4, 2, 1, 2, 2, 1, 0, 0,
                        2, 2, 2, 2, 2, 3, 3, 2, 2, 2, 1, 1, 1, 1, 1,
                        2, 2, 2, 2, 2, 2};
  int depth_delta [38] = '{1, 1, 1, 2, 2, 4, 0, 0, 0, 0, 0, -1, -1, -2, -1, 1, 1,
                           -1, -1, -1, -1, -1, -2, -1, -1, -1, -1, 0, 0, 0, 0, 0,
                           -1, -1, -1, -1, -1, -1};

  fsa_out_t    expected_words[$];
  int          failures = 0;
  int          words_sent;
  int          words_checked;
  int          status_seen [4];
  int          ops_seen [64];
  int unsigned cycle_cnt = 0;
  bit          steady_sender;  // no gaps while set

  // stack helpers
  function automatic logic [31:0] peek_item(int depth_idx);
    if (depth_idx == 0) return tos_word;
    if (depth_idx >= data_cnt) return '0;
    return data_mem[data_cnt - 1 - depth_idx];
  endfunction

  function automatic void push_word(logic [31:0] v);
    if (data_cnt > FSA_DATA_DEPTH) return;
    if (data_cnt >= 1) data_mem[data_cnt - 1] = tos_word;
    tos_word = v;
    data_cnt++;
  endfunction

  function automatic logic [31:0] pop_word();
    logic [31:0] v;
    v = tos_word;
    tos_word = (data_cnt >= 2) ? data_mem[data_cnt - 2] : '0;
    if (data_cnt > 0) data_cnt--;
    return v;
  endfunction

  // truncating division on magnitudes so min / -1 wraps without trapping
  function automatic void div_trunc(input logic [31:0] n, input logic [31:0] d,
                                    output logic [31:0] quo, output logic [31:0] rem);
    logic [31:0] un;
    logic [31:0] ud;
    un  = n[31] ? -n : n;
    ud  = d[31] ? -d : d;
    quo = un / ud;
    rem = un % ud;
    if (n[31] != d[31]) quo = -quo;
    if (n[31]) rem = -rem;
  endfunction

  function automatic logic [31:0] as_flag(bit c);
    return c ? TRUE_WORD : '0;
  endfunction

  // advance the mirror by one command word and give the result it should show
  function automatic fsa_out_t exec_word(logic [5:0] op, logic [31:0] lit);
    fsa_out_t    res;
    fsa_status_e st;
    logic [31:0] a, b, c, q, r, x1, x2, x3, x4;
    st = ST_OK;
    if (op < 38) begin
      if (data_cnt < need_cnt[op]) st = ST_UNDER;
      else if ((op == OP_R_FROM || op == OP_R_FETCH) && ret_cnt == 0) st = ST_UNDER;
      else if (op == OP_PICK && tos_word > 32'(data_cnt - 2)) st = ST_UNDER;
      else if (depth_delta[op] > 0 && data_cnt + depth_delta[op] > FSA_DATA_DEPTH + 1)
        st = ST_OVER;
      else if (op == OP_TO_R && ret_cnt >= FSA_RETURN_DEPTH) st = ST_OVER;
      else if ((op == OP_DIV || op == OP_MOD || op == OP_STAR_SLASH ||
                op == OP_STAR_SLASH_MOD) && tos_word == 0) st = ST_DIVZ;
    end
    if (st == ST_OK && op < 38) begin
      case (op)
        OP_LIT:      push_word(lit);
        OP_DUP:      push_word(tos_word);
        OP_OVER:     push_word(peek_item(1));
        OP_TWO_DUP: begin
          push_word(peek_item(1));
          push_word(peek_item(1));
        end
        OP_TWO_OVER: begin
          push_word(peek_item(3));
          push_word(peek_item(3));
        end
        OP_FOUR_DUP: begin
          repeat (4) push_word(peek_item(3));
        end
        OP_SWAP: begin
          b = pop_word(); a = pop_word();
          push_word(b); push_word(a);
        end
        OP_ROT: begin
          c = pop_word(); b = pop_word(); a = pop_word();
          push_word(b); push_word(c); push_word(a);
        end
        OP_NROT: begin
          c = pop_word(); b = pop_word(); a = pop_word();
          push_word(c); push_word(a); push_word(b);
        end
        OP_TWO_SWAP: begin
          x4 = pop_word(); x3 = pop_word(); x2 = pop_word(); x1 = pop_word();
          push_word(x3); push_word(x4); push_word(x1); push_word(x2);
        end
        OP_PICK:     tos_word = peek_item(int'(tos_word) + 1);
        OP_DROP:     void'(pop_word());
        OP_NIP: begin
          b = pop_word(); void'(pop_word()); push_word(b);
        end
        OP_TWO_DROP: begin
          void'(pop_word()); void'(pop_word());
        end
        OP_TO_R: begin
          ret_mem[ret_cnt] = pop_word();
          ret_cnt++;
        end
        OP_R_FROM: begin
          ret_cnt--;
          push_word(ret_mem[ret_cnt]);
        end
        OP_R_FETCH:  push_word(ret_mem[ret_cnt - 1]);
        OP_STAR_SLASH, OP_STAR_SLASH_MOD: begin
          c = pop_word(); b = pop_word(); a = pop_word();
          div_trunc(a * b, c, q, r);
          if (op == OP_STAR_SLASH_MOD) push_word(r);
          push_word(q);
        end
        OP_NEGATE:   tos_word = -tos_word;
        OP_ABS:      if (tos_word[31]) tos_word = -tos_word;
        OP_ZERO_EQ:  tos_word = as_flag(tos_word == 0);
        OP_ZERO_LT:  tos_word = as_flag(tos_word[31]);
        OP_ZERO_GT:  tos_word = as_flag($signed(tos_word) > 0);
        default: begin
          b = pop_word(); a = pop_word();
          case (op)
            OP_ADD: c = a + b;
            OP_SUB: c = a - b;
            OP_MUL: c = a * b;
            OP_DIV: div_trunc(a, b, c, r);
            OP_MOD: div_trunc(a, b, q, c);
            OP_AND: c = a & b;
            OP_OR:  c = a | b;
            OP_XOR: c = a ^ b;
            OP_EQ:  c = as_flag(a == b);
            OP_GT:  c = as_flag($signed(a) > $signed(b));
            OP_LT:  c = as_flag($signed(a) < $signed(b));
            OP_NE:  c = as_flag(a != b);
            OP_GE:  c = as_flag($signed(a) >= $signed(b));
            default: c = as_flag($signed(a) <= $signed(b));
          endcase
          push_word(c);
        end
      endcase
    end
    res.top_value    = (data_cnt == 0) ? '0 : tos_word;
    res.data_depth   = 6'(data_cnt);
    res.return_depth = 6'(ret_cnt);
    res.status       = st;
    return res;
  endfunction

  // clock and run limit
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_cnt, expected_words.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result checker: the strobe and payload are sampled before this edge updates them
  always @(posedge clk_i) begin
    fsa_out_t want;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: %p", result_o);
        failures++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        status_seen[want.status]++;
        if (result_o.top_value !== want.top_value) begin
          $error("top_value: expected %0d, actual %0d", want.top_value, result_o.top_value);
          failures++;
        end
        if (result_o.data_depth !== want.data_depth) begin
          $error("data_depth: expected %0d, actual %0d", want.data_depth,
                 result_o.data_depth);
          failures++;
        end
        if (result_o.return_depth !== want.return_depth) begin
          $error("return_depth: expected %0d, actual %0d", want.return_depth,
                 result_o.return_depth);
          failures++;
        end
        if (result_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, result_o.status);
          failures++;
        end
      end
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady_sender || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // send one command word; start stays high into the next call when there is no gap
  task automatic send_word(input logic [5:0] op, input logic [31:0] lit);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= '{op: op, value: lit};
    // the busy seen here is the value before this edge
    do @(posedge clk_i); while (busy);
    expected_words.push_back(exec_word(op, lit));
    ops_seen[op]++;
    words_sent++;
  endtask

  task automatic test_empty_stacks();
    send_word(OP_DROP, '0);      // data underflow
    send_word(OP_R_FROM, '0);    // return underflow
    send_word(OP_R_FETCH, '0);
    send_word(OP_TO_R, '0);
  endtask

  task automatic test_shuffles();
    send_word(OP_LIT, MIN_WORD);
    send_word(OP_LIT, MAX_WORD);
    send_word(OP_LIT, 32'd3);
    send_word(OP_LIT, 32'hffff_fffe);
    send_word(OP_OVER, '0);
    send_word(OP_ROT, '0);
    send_word(OP_NROT, '0);
    send_word(OP_TWO_SWAP, '0);
    send_word(OP_TWO_OVER, '0);
    send_word(OP_TO_R, '0);
    send_word(OP_R_FETCH, '0);
    send_word(OP_R_FROM, '0);
    send_word(OP_NIP, '0);
    send_word(OP_LIT, 32'd2);
    send_word(OP_PICK, '0);      // index two, valid
    send_word(OP_LIT, 32'hffff_ffff);
    send_word(OP_PICK, '0);      // negative index
    send_word(6'd63, 32'h1234_5678);  // unused opcode
  endtask

  task automatic test_alu_edges();
    send_word(OP_LIT, MIN_WORD);
    send_word(OP_LIT, 32'hffff_ffff);
    send_word(OP_TWO_DUP, '0);
    send_word(OP_DIV, '0);       // most negative over -1 wraps
    send_word(OP_DROP, '0);
    send_word(OP_MOD, '0);
    send_word(OP_LIT, '0);
    send_word(OP_DIV, '0);       // zero divisor
    send_word(OP_DROP, '0);
    send_word(OP_LIT, MIN_WORD);
    send_word(OP_NEGATE, '0);
    send_word(OP_ABS, '0);
    send_word(OP_LIT, 32'd7);
    send_word(OP_LIT, '0);
    send_word(OP_STAR_SLASH, '0);
    send_word(OP_LIT, 32'hffff_fffd);
    send_word(OP_STAR_SLASH_MOD, '0);
    send_word(OP_ZERO_GT, '0);
  endtask

  task automatic test_full_data_stack();
    send_word(OP_LIT, 32'h5a5a_a5a5);
    repeat (9) send_word(OP_FOUR_DUP, '0);  // the fifth and later ones overflow
    send_word(OP_LIT, '0);
    send_word(OP_R_FETCH, '0);
    repeat (6) send_word(OP_TWO_DROP, '0);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return MIN_WORD;
      1: return MAX_WORD;
      2: return 32'hffff_ffff;
      3: return '0;
      4: return 32'($urandom_range(0, 9)) - 32'd4;
      default: return $urandom;
    endcase
  endfunction

  // opcode by phase: balanced, pushing, popping, return-stack traffic
  function automatic logic [5:0] rand_op(int phase);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return 6'($urandom_range(38, 63));
    case (phase)
      1: if (roll < 55) return (roll < 45) ? OP_LIT : OP_FOUR_DUP;
      2: if (roll < 50) return (roll < 25) ? OP_TWO_DROP : OP_DROP;
      3: if (roll < 60) return (roll < 35) ? OP_TO_R : ((roll < 50) ? OP_R_FROM : OP_R_FETCH);
      default: if (roll < 25) return OP_LIT;
    endcase
    return 6'($urandom_range(0, 37));
  endfunction

  task automatic test_random_words(int unsigned count);
    int          phase;
    int unsigned n;
    logic [5:0]  op;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 24) == 0) begin
        phase         = $urandom_range(0, 3);
        steady_sender = ($urandom_range(0, 3) == 0);
      end
      op = rand_op(phase);
      // a small index in front of most picks so that they mostly succeed
      if (op == OP_PICK && $urandom_range(0, 3) != 0) begin
        send_word(OP_LIT, 32'($urandom_range(0, (data_cnt > 1) ? data_cnt - 1 : 0)));
        n++;
      end
      send_word(op, rand_value());
      n++;
    end
    steady_sender = 1'b0;
  endtask

  initial begin
    int unsigned wait_cnt;
    int          op_kinds;
    start         = 1'b0;
    cmd_i         = '0;
    rst_ni        = 1'b0;
    steady_sender = 1'b0;
    tos_word      = '0;
    data_cnt      = 0;
    ret_cnt       = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stacks();
    test_shuffles();
    test_alu_edges();
    test_full_data_stack();
    test_random_words(400);

    start <= 1'b0;
    wait_cnt = 0;
    while (expected_words.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    op_kinds = 0;
    for (int n = 0; n < 64; n++) begin
      if (ops_seen[n] != 0) op_kinds++;
    end

    $display("%0d command words sent over %0d opcodes, %0d results checked",
             words_sent, op_kinds, words_checked);
    $display("status ok %0d, underflow %0d, overflow %0d, zero divisor %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (failures == 0 && expected_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", failures, expected_words.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
